// File: rtl/assert_macros.svh
// Assertion helper macros shared by the block's RTL files.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rn, cond, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error(msg);

// Antecedent in a cycle requires consequent in the same cycle.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/pbgm_pkg.sv
// Package for the piecewise bilinear grid map: sizes, types, codes, helpers.
// No dependencies; used by every module of the block but pbgm_ram.
package pbgm_pkg;

  // Grid sizing
  localparam int MAX_CELLS  = 16;
  localparam int COORD_W    = 32;
  localparam int GRID_SIDE  = MAX_CELLS + 1;
  localparam int GIDX_W     = $clog2(GRID_SIDE);
  localparam int BANK_SIDE  = (GRID_SIDE + 1) / 2;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS  = 4;

  // Field widths of the transaction ports
  localparam int CELL_W    = 5;
  localparam int IDX_W     = 5;
  localparam int FIELD_W   = 32;
  localparam int PARAM_W   = 17;
  localparam int FRAC_BITS = 16;
  localparam int SPLIT_W   = PARAM_W + CELL_W;
  localparam int IP_W      = SPLIT_W - FRAC_BITS;

  // Datapath widths
  localparam int WGT_W  = 2 * PARAM_W - 1;   // weights reach 2^32
  localparam int PROD_W = COORD_W + WGT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QSHIFT = 2 * FRAC_BITS;

  // Queues
  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int OF_DEPTH = 8;
  localparam int OF_AW    = $clog2(OF_DEPTH);

  // Config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_U = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_V = 1'b1;

  // Transaction kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(1) << FRAC_BITS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic [BANK_AW-1:0]        baddr_t;
  typedef logic [PARAM_W-1:0]        frac_t;
  typedef logic [CELL_W-1:0]         cells_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [GIDX_W-1:0]         gidx_t;
  typedef logic [1:0]                bank_t;
  typedef logic [WGT_W-1:0]          wgt_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [Q_AW-1:0]           qptr_t;
  typedef logic [Q_AW:0]             qcnt_t;
  typedef logic [OF_AW-1:0]          ofptr_t;
  typedef logic [OF_AW:0]            ofcnt_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Classified transaction held between front and back
  typedef struct packed {
    logic                       is_eval;
    bank_t                      wr_bank;
    baddr_t [NUM_BANKS-1:0]     addr;
    logic                       col_odd;
    logic                       row_odd;
    frac_t                      s;
    frac_t                      t;
    coord_t                     x;
    coord_t                     y;
  } qent_t;

  typedef struct packed {
    logic  vld;
    qent_t ent;
  } qhead_t;

  typedef struct packed {
    gidx_t idx;
    frac_t frac;
  } split_t;

  // Zero acts as one, counts above the grid limit act as the limit
  function automatic cells_t eff_cells(input cells_t n);
    cells_t r;
    r = n;
    if (n == '0) r = CELL_W'(1);
    else if (n > CELL_W'(MAX_CELLS)) r = CELL_W'(MAX_CELLS);
    return r;
  endfunction

  // Cell index and local fraction of one parameter
  function automatic split_t split_param(input frac_t p, input cells_t n);
    frac_t              pc;
    logic [SPLIT_W-1:0] sc;
    logic [IP_W-1:0]    ip;
    logic [IP_W-1:0]    nl;
    split_t             r;
    pc = (p > ONE_Q16) ? ONE_Q16 : p;
    sc = SPLIT_W'(pc) * SPLIT_W'(n);
    ip = sc[SPLIT_W-1:FRAC_BITS];
    nl = IP_W'(n);
    if (ip >= nl) ip = nl - IP_W'(1);
    r.idx  = GIDX_W'(ip);
    r.frac = PARAM_W'(sc - {ip, FRAC_BITS'(0)});
    return r;
  endfunction

  // Address inside a parity bank: banks split the grid by row and column parity
  function automatic baddr_t bank_addr(input gidx_t row, input gidx_t col);
    return baddr_t'(int'(row >> 1) * BANK_SIDE + int'(col >> 1));
  endfunction

endpackage

// File: rtl/piecewise_bilinear_grid_map_top.sv
// Top level of the piecewise bilinear grid map: config registers, front and back ends.
// Depends on pbgm_pkg, pbgm_front and pbgm_back.
//
// Maps (u,v) in Q1.16 to a point blended from a grid of signed Q16.16 control
// points. A transaction with kind 0 stores one control point at (col,row); one
// with kind 1 returns the bilinear blend of the four corners of the cell that
// (u,v) falls in, rounded toward zero. The block takes one transaction per
// cycle in steady state, loads and evaluations mixed freely. An evaluation
// result passes the front queue, the registered corner read (corner weights
// are multiplied in the same cycle), the corner multiply, two adder levels
// and the output FIFO write before it shows on out_valid. The four corners
// come out in the same cycle because the grid sits in four RAM banks split
// by row and column parity, so each bank holds exactly one corner of any
// cell. Up to eight evaluation results may be in flight or waiting; when
// the output side stalls that long, the four-entry front queue fills and
// in_stall rises. Control points are not cleared at reset: evaluating a cell
// with a corner never loaded gives an undefined result. Loads with col or
// row above 16 are taken and dropped. The user must write cells_u and
// cells_v (0 acts as 1, above 16 acts as 16) only while no transaction is
// in flight; the block itself does not enforce this.

module piecewise_bilinear_grid_map_top (
  input  logic                clk,
  input  logic                rst_n,
  // input transaction channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [4:0]          in_point_col,
  input  logic [4:0]          in_point_row,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic [16:0]         in_param_u,
  input  logic [16:0]         in_param_v,
  // result transaction channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result_x,
  output logic signed [31:0]  out_result_y,
  // configuration write port
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [4:0]          cfg_wdata
);

  pbgm_pkg::cells_t cells_u_r, cells_u_nxt;
  pbgm_pkg::cells_t cells_v_r, cells_v_nxt;
  pbgm_pkg::qhead_t head;
  logic             pop;

  // Config register decode
  always_comb begin
    cells_u_nxt = cells_u_r;
    cells_v_nxt = cells_v_r;
    if (cfg_we) begin
      unique case (pbgm_pkg::cfg_idx_t'(cfg_index))
        pbgm_pkg::REG_CELLS_U: cells_u_nxt = cfg_wdata;
        pbgm_pkg::REG_CELLS_V: cells_v_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_u_r <= pbgm_pkg::cells_t'(1);
      cells_v_r <= pbgm_pkg::cells_t'(1);
    end else begin
      cells_u_r <= cells_u_nxt;
      cells_v_r <= cells_v_nxt;
    end
  end

  // Front: accept, classify, queue
  pbgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_point_col (in_point_col),
    .in_point_row (in_point_row),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_param_u   (in_param_u),
    .in_param_v   (in_param_v),
    .cells_u      (cells_u_r),
    .cells_v      (cells_v_r),
    .head         (head),
    .pop          (pop)
  );

  // Back: grid storage and blend pipeline
  pbgm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result_x (out_result_x),
    .out_result_y (out_result_y)
  );

endmodule

// File: rtl/pbgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced once per grid bank.
module pbgm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pbgm_front.sv
// Front end: accepts input transactions, classifies them, queues them for the back end.
// Depends on pbgm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbgm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  pbgm_pkg::idx_t     in_point_col,
  input  pbgm_pkg::idx_t     in_point_row,
  input  pbgm_pkg::field_t   in_point_x,
  input  pbgm_pkg::field_t   in_point_y,
  input  pbgm_pkg::frac_t    in_param_u,
  input  pbgm_pkg::frac_t    in_param_v,
  input  pbgm_pkg::cells_t   cells_u,
  input  pbgm_pkg::cells_t   cells_v,
  output pbgm_pkg::qhead_t   head,
  input  logic               pop
);

  pbgm_pkg::qent_t  q_mem_r [pbgm_pkg::Q_DEPTH];
  pbgm_pkg::qptr_t  wp_r, wp_nxt;
  pbgm_pkg::qptr_t  rp_r, rp_nxt;
  pbgm_pkg::qcnt_t  cnt_r, cnt_nxt;
  pbgm_pkg::qent_t  ent;
  logic             accept;
  logic             in_range;
  logic             push;

  assign in_stall = (cnt_r == pbgm_pkg::qcnt_t'(pbgm_pkg::Q_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign in_range = (in_point_col <= pbgm_pkg::idx_t'(pbgm_pkg::MAX_CELLS)) &&
                    (in_point_row <= pbgm_pkg::idx_t'(pbgm_pkg::MAX_CELLS));
  // out-of-range loads are taken and dropped
  assign push     = accept && ((in_kind == pbgm_pkg::KIND_EVAL) || in_range);

  // Classification
  always_comb begin
    pbgm_pkg::split_t su;
    pbgm_pkg::split_t sv;
    pbgm_pkg::gidx_t  i1;
    pbgm_pkg::gidx_t  j1;
    pbgm_pkg::gidx_t  c;
    pbgm_pkg::gidx_t  r;
    pbgm_pkg::bank_t  bsel;
    pbgm_pkg::baddr_t laddr;
    su    = pbgm_pkg::split_param(in_param_u, pbgm_pkg::eff_cells(cells_u));
    sv    = pbgm_pkg::split_param(in_param_v, pbgm_pkg::eff_cells(cells_v));
    i1    = su.idx + pbgm_pkg::gidx_t'(1);
    j1    = sv.idx + pbgm_pkg::gidx_t'(1);
    laddr = pbgm_pkg::bank_addr(pbgm_pkg::gidx_t'(in_point_row),
                                pbgm_pkg::gidx_t'(in_point_col));
    ent.is_eval = (in_kind == pbgm_pkg::KIND_EVAL);
    ent.wr_bank = {in_point_row[0], in_point_col[0]};
    ent.col_odd = su.idx[0];
    ent.row_odd = sv.idx[0];
    ent.s       = su.frac;
    ent.t       = sv.frac;
    ent.x       = pbgm_pkg::coord_t'(in_point_x);
    ent.y       = pbgm_pkg::coord_t'(in_point_y);
    for (int b = 0; b < pbgm_pkg::NUM_BANKS; b++) begin
      bsel = pbgm_pkg::bank_t'(b);
      // each bank holds exactly one corner of any cell
      c = (su.idx[0] == bsel[0]) ? su.idx : i1;
      r = (sv.idx[0] == bsel[1]) ? sv.idx : j1;
      ent.addr[b] = ent.is_eval ? pbgm_pkg::bank_addr(r, c) : laddr;
    end
  end

  // Decoupling queue
  always_comb begin
    wp_nxt  = push ? wp_r + pbgm_pkg::qptr_t'(1) : wp_r;
    rp_nxt  = pop  ? rp_r + pbgm_pkg::qptr_t'(1) : rp_r;
    cnt_nxt = cnt_r + pbgm_pkg::qcnt_t'(push) - pbgm_pkg::qcnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= ent;
    end
  end

  assign head.vld = (cnt_r != '0);
  assign head.ent = q_mem_r[rp_r];

  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, cnt_r != '0, "pop from empty queue")
  `ASSERT_ALWAYS(a_q_bound, clk, rst_n, cnt_r <= pbgm_pkg::qcnt_t'(pbgm_pkg::Q_DEPTH), "queue overfill")

endmodule

// File: rtl/pbgm_back.sv
// Back end: grid banks, corner read, bilinear blend pipeline and output FIFO.
// Depends on pbgm_pkg, pbgm_ram and assert_macros.svh.
`include "assert_macros.svh"

module pbgm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pbgm_pkg::qhead_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pbgm_pkg::field_t   out_result_x,
  output pbgm_pkg::field_t   out_result_y
);

  logic [2*pbgm_pkg::COORD_W-1:0] rd [pbgm_pkg::NUM_BANKS];
  logic                issue_eval;
  logic                issue_load;
  pbgm_pkg::frac_t     rs, rt;
  pbgm_pkg::wgt_t      w_nxt [pbgm_pkg::NUM_BANKS];

  // stage valids
  logic                s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;

  // stage payload
  logic                s1_codd_r, s1_rodd_r;
  pbgm_pkg::wgt_t      w_r  [pbgm_pkg::NUM_BANKS];
  pbgm_pkg::coord_t    cx [pbgm_pkg::NUM_BANKS];
  pbgm_pkg::coord_t    cy [pbgm_pkg::NUM_BANKS];
  pbgm_pkg::prod_t     px_r [pbgm_pkg::NUM_BANKS];
  pbgm_pkg::prod_t     py_r [pbgm_pkg::NUM_BANKS];
  pbgm_pkg::sum_t      sxa_r, sxb_r, sya_r, syb_r;
  pbgm_pkg::sum_t      sx_r, sy_r;
  pbgm_pkg::field_t    rx, ry;

  // output FIFO and credit count
  pbgm_pkg::field_t    of_x_r [pbgm_pkg::OF_DEPTH];
  pbgm_pkg::field_t    of_y_r [pbgm_pkg::OF_DEPTH];
  pbgm_pkg::ofptr_t    of_wp_r, of_wp_nxt;
  pbgm_pkg::ofptr_t    of_rp_r, of_rp_nxt;
  pbgm_pkg::ofcnt_t    of_cnt_r, of_cnt_nxt;
  pbgm_pkg::ofcnt_t    resv_r, resv_nxt;
  logic                of_push, of_pop;

  // Issue: an evaluation needs a free output slot reserved up front
  assign pop = head.vld &&
               (!head.ent.is_eval || (resv_r < pbgm_pkg::ofcnt_t'(pbgm_pkg::OF_DEPTH)));
  assign issue_eval = pop && head.ent.is_eval;
  assign issue_load = pop && !head.ent.is_eval;

  for (genvar b = 0; b < pbgm_pkg::NUM_BANKS; b++) begin : g_bank
    pbgm_ram #(
      .WIDTH (2 * pbgm_pkg::COORD_W),
      .DEPTH (pbgm_pkg::BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (issue_load && (head.ent.wr_bank == pbgm_pkg::bank_t'(b))),
      .waddr (head.ent.addr[0]),
      .wdata ({head.ent.x, head.ent.y}),
      .raddr (head.ent.addr[b]),
      .rdata (rd[b])
    );
  end

  // Corner weights, order p00 p10 p11 p01
  always_comb begin
    rs = pbgm_pkg::ONE_Q16 - head.ent.s;
    rt = pbgm_pkg::ONE_Q16 - head.ent.t;
    w_nxt[0] = pbgm_pkg::wgt_t'(rs) * pbgm_pkg::wgt_t'(rt);
    w_nxt[1] = pbgm_pkg::wgt_t'(head.ent.s) * pbgm_pkg::wgt_t'(rt);
    w_nxt[2] = pbgm_pkg::wgt_t'(head.ent.s) * pbgm_pkg::wgt_t'(head.ent.t);
    w_nxt[3] = pbgm_pkg::wgt_t'(rs) * pbgm_pkg::wgt_t'(head.ent.t);
  end

  // Route banks to corners by cell parity
  always_comb begin
    pbgm_pkg::bank_t bk [pbgm_pkg::NUM_BANKS];
    bk[0] = {s1_rodd_r, s1_codd_r};
    bk[1] = {s1_rodd_r, !s1_codd_r};
    bk[2] = {!s1_rodd_r, !s1_codd_r};
    bk[3] = {!s1_rodd_r, s1_codd_r};
    for (int k = 0; k < pbgm_pkg::NUM_BANKS; k++) begin
      cx[k] = rd[bk[k]][2*pbgm_pkg::COORD_W-1:pbgm_pkg::COORD_W];
      cy[k] = rd[bk[k]][pbgm_pkg::COORD_W-1:0];
    end
  end

  // Divide by 2^32 rounding toward zero
  always_comb begin
    rx = pbgm_pkg::field_t'(sx_r >>> pbgm_pkg::QSHIFT) +
         pbgm_pkg::field_t'(sx_r[pbgm_pkg::SUM_W-1] && (sx_r[pbgm_pkg::QSHIFT-1:0] != '0));
    ry = pbgm_pkg::field_t'(sy_r >>> pbgm_pkg::QSHIFT) +
         pbgm_pkg::field_t'(sy_r[pbgm_pkg::SUM_W-1] && (sy_r[pbgm_pkg::QSHIFT-1:0] != '0));
  end

  assign of_push = s4_vld_r;
  assign of_pop  = out_valid && !out_stall;

  always_comb begin
    of_wp_nxt  = of_push ? of_wp_r + pbgm_pkg::ofptr_t'(1) : of_wp_r;
    of_rp_nxt  = of_pop  ? of_rp_r + pbgm_pkg::ofptr_t'(1) : of_rp_r;
    of_cnt_nxt = of_cnt_r + pbgm_pkg::ofcnt_t'(of_push) - pbgm_pkg::ofcnt_t'(of_pop);
    resv_nxt   = resv_r + pbgm_pkg::ofcnt_t'(issue_eval) - pbgm_pkg::ofcnt_t'(of_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      of_wp_r  <= '0;
      of_rp_r  <= '0;
      of_cnt_r <= '0;
      resv_r   <= '0;
    end else begin
      s1_vld_r <= issue_eval;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      of_wp_r  <= of_wp_nxt;
      of_rp_r  <= of_rp_nxt;
      of_cnt_r <= of_cnt_nxt;
      resv_r   <= resv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_codd_r <= head.ent.col_odd;
    s1_rodd_r <= head.ent.row_odd;
    for (int k = 0; k < pbgm_pkg::NUM_BANKS; k++) begin
      w_r[k]  <= w_nxt[k];
      px_r[k] <= cx[k] * $signed({1'b0, w_r[k]});
      py_r[k] <= cy[k] * $signed({1'b0, w_r[k]});
    end
    sxa_r <= pbgm_pkg::sum_t'(px_r[0]) + pbgm_pkg::sum_t'(px_r[1]);
    sxb_r <= pbgm_pkg::sum_t'(px_r[2]) + pbgm_pkg::sum_t'(px_r[3]);
    sya_r <= pbgm_pkg::sum_t'(py_r[0]) + pbgm_pkg::sum_t'(py_r[1]);
    syb_r <= pbgm_pkg::sum_t'(py_r[2]) + pbgm_pkg::sum_t'(py_r[3]);
    sx_r  <= sxa_r + sxb_r;
    sy_r  <= sya_r + syb_r;
    if (of_push) begin
      of_x_r[of_wp_r] <= rx;
      of_y_r[of_wp_r] <= ry;
    end
  end

  assign out_valid    = (of_cnt_r != '0);
  assign out_result_x = of_x_r[of_rp_r];
  assign out_result_y = of_y_r[of_rp_r];

  `ASSERT_ALWAYS(a_resv_bound, clk, rst_n, resv_r <= pbgm_pkg::ofcnt_t'(pbgm_pkg::OF_DEPTH), "credit count overflow")
  `ASSERT_ALWAYS(a_resv_covers, clk, rst_n, of_cnt_r <= resv_r, "FIFO holds unreserved entries")
  `ASSERT_IMPLIES(a_of_room, clk, rst_n, of_push, (of_cnt_r < pbgm_pkg::ofcnt_t'(pbgm_pkg::OF_DEPTH)) || of_pop, "result pushed into full FIFO")

endmodule
